FILE: rtl/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
// No dependencies; used by the interfaces, the cell, the cell row and the top level.
package lkv_pkg;

   localparam int NUM_CELLS = 16;
   localparam int DATA_W    = 32;
   localparam int RANK_W    = 4;
   localparam int COUNT_W   = 5;
   localparam int CSR_W     = 5;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(NUM_CELLS);

   typedef logic [DATA_W-1:0]  word_type;
   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      APPLY_NONE,
      APPLY_PROMOTE,
      APPLY_FILL,
      APPLY_EVICT
   } apply_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic      look;
      word_type  key;
      rank_type  victim_rank;
      apply_type apply_kind;
      rank_type  promote_rank;
      logic      write_data;
      word_type  value;
   } cell_cmd_type;

   // passed from cell to cell along the row
   typedef struct packed {
      logic     hit;
      word_type hit_value;
      rank_type hit_rank;
      word_type victim_key;
      logic     free_seen;
   } chain_type;

endpackage

FILE: rtl/lkv_req_if.sv
// Request channel interface: valid/ready handshake with func, key and value.
// Depends on lkv_pkg.
interface lkv_req_if;
   logic                             valid;
   logic                             ready;
   logic                             func;
   logic signed [lkv_pkg::DATA_W-1:0] key;
   logic signed [lkv_pkg::DATA_W-1:0] value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);
endinterface

FILE: rtl/lkv_rsp_if.sv
// Response channel interface: valid/ready handshake with hit, read value and eviction.
// Depends on lkv_pkg.
interface lkv_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic signed [lkv_pkg::DATA_W-1:0] read_value;
   logic                             evicted;
   logic signed [lkv_pkg::DATA_W-1:0] evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

FILE: rtl/lkv_cell.sv
// One cache entry: key, value, valid bit and recency rank, with its local compare.
// Depends on lkv_pkg.
module lkv_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lkv_pkg::cell_cmd_type cmd,
   input  lkv_pkg::chain_type    chain_in,
   output lkv_pkg::chain_type    chain_out
);

   logic              valid_ff, valid_in;
   lkv_pkg::rank_type rank_ff, rank_in;
   lkv_pkg::word_type key_ff, key_in;
   lkv_pkg::word_type value_ff, value_in;
   logic              match_ff, match_in;
   logic              victim_ff, victim_in;
   logic              free_ff, free_in;

   logic my_match;
   logic my_victim;
   logic my_free;
   logic target;

   assign my_match  = valid_ff && (key_ff == cmd.key);
   assign my_victim = valid_ff && (rank_ff == cmd.victim_rank);
   assign my_free   = !valid_ff && !chain_in.free_seen;

   always_comb begin
      chain_out = chain_in;
      if (!chain_in.hit && my_match) begin
         chain_out.hit       = 1'b1;
         chain_out.hit_value = value_ff;
         chain_out.hit_rank  = rank_ff;
      end
      if (my_victim) begin
         chain_out.victim_key = key_ff;
      end
      chain_out.free_seen = chain_in.free_seen || !valid_ff;
   end

   always_comb begin
      case (cmd.apply_kind)
         lkv_pkg::APPLY_PROMOTE: target = match_ff;
         lkv_pkg::APPLY_FILL:    target = free_ff;
         lkv_pkg::APPLY_EVICT:   target = victim_ff;
         default:                target = 1'b0;
      endcase
   end

   always_comb begin
      match_in  = match_ff;
      victim_in = victim_ff;
      free_in   = free_ff;
      if (cmd.look) begin
         match_in  = my_match && !chain_in.hit;
         victim_in = my_victim;
         free_in   = my_free;
      end

      valid_in = valid_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (target) begin
         rank_in = '0;
         if (cmd.write_data) begin
            value_in = cmd.value;
         end
         if (cmd.apply_kind != lkv_pkg::APPLY_PROMOTE) begin
            valid_in = 1'b1;
            key_in   = cmd.key;
         end
      end else if (valid_ff) begin
         case (cmd.apply_kind)
            lkv_pkg::APPLY_PROMOTE: begin
               if (rank_ff < cmd.promote_rank) begin
                  rank_in = rank_ff + 1'b1;
               end
            end
            lkv_pkg::APPLY_FILL,
            lkv_pkg::APPLY_EVICT: rank_in = rank_ff + 1'b1;
            default: rank_in = rank_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         rank_ff   <= '0;
         match_ff  <= 1'b0;
         victim_ff <= 1'b0;
         free_ff   <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rank_ff   <= rank_in;
         match_ff  <= match_in;
         victim_ff <= victim_in;
         free_ff   <= free_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

FILE: rtl/lkv_cell_row.sv
// Row of cache cells; lookup results ripple from the first cell to the last.
// Depends on lkv_pkg and lkv_cell.
module lkv_cell_row (
   input  logic                  clock,
   input  logic                  reset,
   input  lkv_pkg::cell_cmd_type cmd,
   output lkv_pkg::chain_type    chain_end
);

   lkv_pkg::chain_type links [lkv_pkg::NUM_CELLS+1];

   assign links[0]  = '0;
   assign chain_end = links[lkv_pkg::NUM_CELLS];

   for (genvar g = 0; g < lkv_pkg::NUM_CELLS; g++) begin : g_cell
      lkv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (links[g]),
         .chain_out (links[g+1])
      );
   end

endmodule

FILE: rtl/lru_key_value_cache.sv
// LRU key/value cache top level: transaction control, occupancy, capacity register.
// Depends on lkv_pkg, lkv_req_if, lkv_rsp_if and lkv_cell_row.
//
// Usage:
//   req carries one transaction: func (0 get, 1 put), key and value. rsp returns
//   exactly one transaction per request: hit, read_value (get hit only),
//   evicted and evicted_key (put that replaced the least recent entry).
//   csr_write_enable/csr_write_data set the capacity in use (0 acts as 1,
//   values above 16 act as 16); write it only while the cache is idle.
// Timing:
//   A request is compared against all sixteen cells in the cycle after it is
//   taken; the state update and the response register load follow in the
//   apply state once the response register is free. The next request can be
//   taken in that update cycle, so lookups and updates alternate in the cell row.
// Reset:
//   Clears all valid bits, ranks and occupancy; capacity returns to 16.
// Stall:
//   While a response waits and rsp.ready is low, one further request is looked
//   up and then held until the response register frees; req.ready stays low.
module lru_key_value_cache (
   input  logic                          clock,
   input  logic                          reset,
   lkv_req_if.sink                       req,
   lkv_rsp_if.source                     rsp,
   input  logic                          csr_write_enable,
   input  logic [lkv_pkg::CSR_W-1:0]     csr_write_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_APPLY
   } state_type;

   typedef struct packed {
      logic              hit;
      lkv_pkg::word_type read_value;
      logic              evicted;
      lkv_pkg::word_type evicted_key;
   } result_type;

   state_type           state_ff;
   logic                func_ff;
   lkv_pkg::word_type   key_ff;
   lkv_pkg::word_type   value_ff;
   lkv_pkg::apply_type  kind_ff, kind_in;
   lkv_pkg::rank_type   promote_rank_ff;
   result_type          result_ff, result_in;
   lkv_pkg::count_type  occupancy_ff;
   lkv_pkg::count_type  capacity_ff;
   logic                rsp_valid_ff;
   result_type          rsp_data_ff;

   lkv_pkg::cell_cmd_type cmd;
   lkv_pkg::chain_type    chain_end;
   lkv_pkg::count_type    capacity_eff;
   logic                  out_free;
   logic                  req_accept;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready  = (state_ff == S_IDLE) || ((state_ff == S_APPLY) && out_free);
   assign req_accept = req.valid && req.ready;

   always_comb begin
      if (capacity_ff == '0) begin
         capacity_eff = lkv_pkg::count_type'(1);
      end else if (capacity_ff > lkv_pkg::count_type'(lkv_pkg::NUM_CELLS)) begin
         capacity_eff = lkv_pkg::count_type'(lkv_pkg::NUM_CELLS);
      end else begin
         capacity_eff = capacity_ff;
      end
   end

   always_comb begin
      cmd.look         = (state_ff == S_LOOK);
      cmd.key          = key_ff;
      cmd.victim_rank  = lkv_pkg::rank_type'(occupancy_ff - 1'b1);
      cmd.apply_kind   = ((state_ff == S_APPLY) && out_free) ? kind_ff : lkv_pkg::APPLY_NONE;
      cmd.promote_rank = promote_rank_ff;
      cmd.write_data   = func_ff;
      cmd.value        = value_ff;
   end

   lkv_cell_row u_row (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .chain_end (chain_end)
   );

   // decision taken at the end of the lookup cycle
   always_comb begin
      result_in = '0;
      kind_in   = lkv_pkg::APPLY_NONE;
      if (chain_end.hit) begin
         kind_in       = lkv_pkg::APPLY_PROMOTE;
         result_in.hit = 1'b1;
         if (!func_ff) begin
            result_in.read_value = chain_end.hit_value;
         end
      end else if (func_ff) begin
         if ((occupancy_ff < capacity_eff) && chain_end.free_seen) begin
            kind_in = lkv_pkg::APPLY_FILL;
         end else if (occupancy_ff != '0) begin
            kind_in               = lkv_pkg::APPLY_EVICT;
            result_in.evicted     = 1'b1;
            result_in.evicted_key = chain_end.victim_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= lkv_pkg::APPLY_NONE;
         occupancy_ff <= '0;
         capacity_ff  <= lkv_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if ((state_ff == S_APPLY) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               kind_ff  <= kind_in;
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (out_free) begin
                  if (kind_ff == lkv_pkg::APPLY_FILL) begin
                     occupancy_ff <= occupancy_ff + 1'b1;
                  end
                  state_ff <= req_accept ? S_LOOK : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      if (req_accept) begin
         func_ff  <= req.func;
         key_ff   <= $unsigned(req.key);
         value_ff <= $unsigned(req.value);
      end
      if (state_ff == S_LOOK) begin
         result_ff       <= result_in;
         promote_rank_ff <= chain_end.hit_rank;
      end
      if ((state_ff == S_APPLY) && out_free) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit         = rsp_data_ff.hit;
   assign rsp.read_value  = $signed(rsp_data_ff.read_value);
   assign rsp.evicted     = rsp_data_ff.evicted;
   assign rsp.evicted_key = $signed(rsp_data_ff.evicted_key);

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for lru_key_value_cache: a directed part, then random gets and puts
// over several capacity settings, each checked field by field against an in-bench cache model.
// Depends on lkv_pkg, lkv_req_if, lkv_rsp_if and the lru_key_value_cache RTL.
module tb_top;

   localparam int CLOCK_HALF     = 6;
   localparam int STALL_LIMIT    = 5000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int REPORT_LIMIT   = 10;
   localparam int KEY_POOL_SIZE  = 24;
   localparam int PHASE_ITEMS    = 133;
   localparam logic OP_GET       = 1'b0;
   localparam logic OP_PUT       = 1'b1;

   typedef struct {
      logic              hit;
      lkv_pkg::word_type read_value;
      logic              evicted;
      lkv_pkg::word_type evicted_key;
   } cache_reply_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_write_enable;
   logic [lkv_pkg::CSR_W-1:0]     csr_write_data;

   lkv_req_if req_if ();
   lkv_rsp_if rsp_if ();

   lru_key_value_cache dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // cache model state
   logic                      line_valid [lkv_pkg::NUM_CELLS];
   lkv_pkg::word_type         line_key   [lkv_pkg::NUM_CELLS];
   lkv_pkg::word_type         line_value [lkv_pkg::NUM_CELLS];
   int                        line_rank  [lkv_pkg::NUM_CELLS];
   int                        lines_held;
   logic [lkv_pkg::CSR_W-1:0] capacity_setting;

   cache_reply_type   pending_replies [$];
   cache_reply_type   oldest_reply;
   lkv_pkg::word_type key_pool [KEY_POOL_SIZE];

   int sender_idle_pct;
   int receiver_idle_pct;
   int fail_count;
   int stall_cycles;
   int gets_sent;
   int puts_sent;
   int hits_seen;
   int evictions_seen;
   int capacity_writes;

   initial clock = 1'b0;
   always #CLOCK_HALF clock = ~clock;

   function automatic int usable_capacity();
      if (capacity_setting == '0) return 1;
      if (capacity_setting > lkv_pkg::CSR_W'(lkv_pkg::NUM_CELLS)) return lkv_pkg::NUM_CELLS;
      return int'(capacity_setting);
   endfunction

   function automatic void bring_to_front(int idx);
      int old_rank;
      old_rank = line_rank[idx];
      for (int i = 0; i < lkv_pkg::NUM_CELLS; i++)
         if (line_valid[i] && line_rank[i] < old_rank) line_rank[i]++;
      line_rank[idx] = 0;
   endfunction

   function automatic void age_all_but(int idx);
      for (int i = 0; i < lkv_pkg::NUM_CELLS; i++)
         if (i != idx && line_valid[i]) line_rank[i]++;
      line_rank[idx] = 0;
   endfunction

   function automatic cache_reply_type predict_access(logic op, lkv_pkg::word_type k,
                                                      lkv_pkg::word_type v);
      cache_reply_type r;
      int found;
      int slot;
      int victim;
      r = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
      found = -1;
      slot = -1;
      victim = -1;
      for (int i = 0; i < lkv_pkg::NUM_CELLS; i++)
         if (found < 0 && line_valid[i] && line_key[i] == k) found = i;
      if (found >= 0) begin
         r.hit = 1'b1;
         if (op == OP_GET) r.read_value = line_value[found];
         else line_value[found] = v;
         bring_to_front(found);
         return r;
      end
      if (op == OP_GET) return r;
      if (lines_held < usable_capacity()) begin
         for (int i = 0; i < lkv_pkg::NUM_CELLS; i++)
            if (slot < 0 && !line_valid[i]) slot = i;
      end
      if (slot >= 0) begin
         line_valid[slot] = 1'b1;
         line_key[slot]   = k;
         line_value[slot] = v;
         age_all_but(slot);
         lines_held++;
         return r;
      end
      for (int i = 0; i < lkv_pkg::NUM_CELLS; i++)
         if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim])) victim = i;
      if (victim < 0) return r;
      r.evicted        = 1'b1;
      r.evicted_key    = line_key[victim];
      line_key[victim]   = k;
      line_value[victim] = v;
      age_all_but(victim);
      return r;
   endfunction

   function automatic void report_failure(string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", what);
   endfunction

   // receiver back-pressure
   initial rsp_if.ready = 1'b0;
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (rsp_if.hit) hits_seen++;
         if (rsp_if.evicted) evictions_seen++;
         if (pending_replies.size() == 0) begin
            report_failure("unexpected response transaction with nothing outstanding");
         end else begin
            oldest_reply = pending_replies.pop_front();
            if (rsp_if.hit !== oldest_reply.hit
                || rsp_if.read_value !== oldest_reply.read_value
                || rsp_if.evicted !== oldest_reply.evicted
                || rsp_if.evicted_key !== oldest_reply.evicted_key) begin
               report_failure($sformatf(
                  "mismatch (exp/got): hit %0b/%0b rd %h/%h ev %0b/%0b ev_key %h/%h",
                  oldest_reply.hit, rsp_if.hit, oldest_reply.read_value, rsp_if.read_value,
                  oldest_reply.evicted, rsp_if.evicted,
                  oldest_reply.evicted_key, rsp_if.evicted_key));
            end
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_access(input logic op, input lkv_pkg::word_type k,
                              input lkv_pkg::word_type v);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.func  = op;
      req_if.key   = k;
      req_if.value = v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_replies.insert(pending_replies.size(), predict_access(op, k, v));
      if (op == OP_GET) gets_sent++;
      else puts_sent++;
      @(negedge clock);
   endtask

   task automatic write_capacity(input logic [lkv_pkg::CSR_W-1:0] cap);
      req_if.valid = 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = cap;
      @(negedge clock);
      csr_write_enable = 1'b0;
      capacity_setting = cap;
      capacity_writes++;
   endtask

   task automatic test_get_put_basics();
      send_access(OP_GET, 32'h0000_0000, 32'h1234_5678);
      send_access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_access(OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_access(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_access(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_access(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_access(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
   endtask

   // capacity below occupancy, zero and above-range settings
   task automatic test_capacity_limits();
      write_capacity(5'd0);
      send_access(OP_PUT, 32'h1234_5678, 32'hA5A5_A5A5);
      send_access(OP_PUT, 32'h0000_0001, 32'h5A5A_5A5A);
      send_access(OP_GET, 32'h1234_5678, 32'h0000_0000);
      send_access(OP_GET, 32'h0000_0001, 32'h0000_0000);
      send_access(OP_PUT, 32'h0000_0001, 32'hFFFF_FFFF);
      write_capacity(5'd31);
      send_access(OP_PUT, 32'h5555_AAAA, 32'hAAAA_5555);
      send_access(OP_GET, 32'h5555_AAAA, 32'h0000_0000);
      write_capacity(5'd1);
      send_access(OP_PUT, 32'h0F0F_F0F0, 32'h0000_0001);
      send_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
   endtask

   task automatic run_random_accesses(input int count);
      logic              op;
      lkv_pkg::word_type k;
      lkv_pkg::word_type v;
      int                span;
      span = usable_capacity() + 4;
      for (int n = 0; n < count; n++) begin
         op = logic'($urandom_range(1));
         if ($urandom_range(99) < 85) k = key_pool[$urandom_range(span - 1)];
         else k = $urandom();
         case ($urandom_range(19))
            0:       v = 32'hFFFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'h7FFF_FFFF;
            default: v = $urandom();
         endcase
         send_access(op, k, v);
      end
   endtask

   task automatic test_random_phases(input int snd_pct, input int rcv_pct,
                                     input logic [lkv_pkg::CSR_W-1:0] caps [4]);
      sender_idle_pct   = snd_pct;
      receiver_idle_pct = rcv_pct;
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         run_random_accesses(PHASE_ITEMS);
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.func      = OP_GET;
      req_if.key       = '0;
      req_if.value     = '0;
      sender_idle_pct   = 11;
      receiver_idle_pct = 82;
      gets_sent = 0;
      puts_sent = 0;
      capacity_writes = 0;
      for (int i = 0; i < lkv_pkg::NUM_CELLS; i++) begin
         line_valid[i] = 1'b0;
         line_key[i]   = '0;
         line_value[i] = '0;
         line_rank[i]  = 0;
      end
      lines_held       = 0;
      capacity_setting = lkv_pkg::CAPACITY_RESET;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_get_put_basics();
      test_capacity_limits();
      test_random_phases(11, 82, '{5'd16, 5'd1, 5'd31, 5'd6});
      test_random_phases(82, 11, '{5'd0, 5'd12, 5'd2, 5'd20});
      test_random_phases(0, 0, '{5'd16, 5'd3, 5'd9, 5'd31});

      req_if.valid = 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("covered %0d gets and %0d puts over %0d capacity settings",
               gets_sent, puts_sent, capacity_writes);
      $display("responses seen: %0d hits, %0d evictions, %0d failures",
               hits_seen, evictions_seen, fail_count);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/lkv_pkg.sv
rtl/lkv_req_if.sv
rtl/lkv_rsp_if.sv
rtl/lkv_cell.sv
rtl/lkv_cell_row.sv
rtl/lru_key_value_cache.sv
sim/tb_top.sv
